// File: design/timed_event_queue_dispatcher_top_defines.svh
// Assertion macros for the timed event queue dispatcher.
`ifndef TIMED_EVENT_QUEUE_DISPATCHER_TOP_DEFINES_SVH
`define TIMED_EVENT_QUEUE_DISPATCHER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TEQD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TEQD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/teqd_pkg.sv
`timescale 1ns / 1ps

package teqd_pkg;

	// Default sizes and fixed field widths.
	localparam int DEF_QUEUE_DEPTH = 32;
	localparam int DEF_WAIT_BITS   = 16;
	localparam int WAIT_IN_W       = 16;
	localparam int LABEL_W         = 8;
	localparam int PAYLOAD_W       = 64;
	localparam int LEVEL_W         = 6;
	localparam logic [LEVEL_W-1:0] LEVEL_RESET = 6'd16;

	// Item operation codes.
	localparam logic OP_ENQUEUE = 1'b0;
	localparam logic OP_TICK    = 1'b1;

	// Controller states.
	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic exec;
	} cmd_t;

endpackage

// File: design/teqd_ctrl.sv
`timescale 1ns / 1ps

module teqd_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	output logic            done,
	output teqd_pkg::cmd_t  cmd
);
	import teqd_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   done_q;

	// State register and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.exec;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.exec = 1'b0;
		busy     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				busy     = 1'b1;
				cmd.exec = 1'b1;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign done = done_q;

endmodule

// File: design/teqd_datapath.sv
`timescale 1ns / 1ps

module teqd_datapath #(
	parameter int QUEUE_DEPTH = teqd_pkg::DEF_QUEUE_DEPTH,
	parameter int WAIT_BITS   = teqd_pkg::DEF_WAIT_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  teqd_pkg::cmd_t                   cmd,
	input  logic                             opcode,
	input  logic [teqd_pkg::WAIT_IN_W-1:0]   delay_ticks,
	input  logic [teqd_pkg::LABEL_W-1:0]     event_label,
	input  logic [teqd_pkg::PAYLOAD_W-1:0]   event_payload,
	input  logic                             run_level,
	input  logic                             cfg_we,
	input  logic [teqd_pkg::LEVEL_W-1:0]     cfg_wdata,
	output logic                             out_valid,
	output logic [teqd_pkg::LABEL_W-1:0]     out_label,
	output logic [teqd_pkg::PAYLOAD_W-1:0]   out_payload,
	output logic                             almost_full,
	output logic                             queue_empty,
	output logic                             error_flag,
	output logic                             overflow
);
	import teqd_pkg::*;

	localparam int PTR_W   = $clog2(QUEUE_DEPTH);
	localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int ENTRY_W = WAIT_BITS + LABEL_W + PAYLOAD_W;

	typedef logic [ENTRY_W-1:0] entry_t;

	// Event memory and its registered head read.
	entry_t mem_q [QUEUE_DEPTH];
	entry_t rd_q;

	// Latched item.
	logic                 op_q;
	logic [WAIT_BITS-1:0] wait_q;
	logic [LABEL_W-1:0]   label_q;
	logic [PAYLOAD_W-1:0] payload_q;
	logic                 run_q;

	// Queue and timing control state.
	logic [PTR_W-1:0]     head_q, tail_q;
	logic [CNT_W-1:0]     count_q;
	logic                 run_prev_q;
	logic [WAIT_BITS-1:0] countdown_q;
	logic                 active_q;
	logic [LABEL_W-1:0]   pend_label_q;
	logic [PAYLOAD_W-1:0] pend_payload_q;
	logic                 error_q;
	logic [LEVEL_W-1:0]   level_q;

	// Next values.
	logic [PTR_W-1:0]     head_d, tail_d;
	logic [CNT_W-1:0]     count_d;
	logic                 run_prev_d;
	logic [WAIT_BITS-1:0] countdown_d;
	logic                 active_d;
	logic [LABEL_W-1:0]   pend_label_d;
	logic [PAYLOAD_W-1:0] pend_payload_d;
	logic                 error_d;
	logic                 wr_en;
	logic                 valid_d;
	logic                 ovf_d;
	logic                 pop;
	logic                 empty_now;
	logic                 full_now;
	logic [WAIT_BITS-1:0] head_wait;

	// Memory write on enqueue and head read every cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[tail_q] <= {wait_q, label_q, payload_q};
		end
		rd_q <= mem_q[head_q];
	end

	// Input item capture.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= opcode;
			wait_q    <= WAIT_BITS'(delay_ticks);
			label_q   <= event_label;
			payload_q <= event_payload;
			run_q     <= run_level;
		end
	end

	assign empty_now = (count_q == '0);
	assign full_now  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head_wait = rd_q[ENTRY_W-1 -: WAIT_BITS];

	// Item execution: enqueue or one tick of the dispatcher.
	always_comb begin
		head_d         = head_q;
		tail_d         = tail_q;
		count_d        = count_q;
		run_prev_d     = run_prev_q;
		countdown_d    = countdown_q;
		active_d       = active_q;
		pend_label_d   = pend_label_q;
		pend_payload_d = pend_payload_q;
		error_d        = error_q;
		wr_en          = 1'b0;
		valid_d        = 1'b0;
		ovf_d          = 1'b0;
		pop            = 1'b0;
		if (cmd.exec) begin
			case (op_q)
				OP_ENQUEUE: begin
					if (full_now) begin
						ovf_d = 1'b1;
					end else begin
						wr_en   = 1'b1;
						tail_d  = (tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
						count_d = count_q + 1'b1;
					end
				end
				default: begin
					run_prev_d = run_q;
					error_d    = error_q | (run_q & empty_now);
					if (active_q) begin
						countdown_d = countdown_q - 1'b1;
						if (countdown_q == WAIT_BITS'(1)) begin
							valid_d  = 1'b1;
							active_d = 1'b0;
							pop      = run_q & ~error_d & ~empty_now;
						end
					end else begin
						pop = run_q & ~run_prev_q & ~error_d & ~empty_now;
					end
					// Pop the head event and start its countdown.
					if (pop) begin
						countdown_d    = (head_wait == '0) ? WAIT_BITS'(1) : head_wait;
						pend_label_d   = rd_q[PAYLOAD_W +: LABEL_W];
						pend_payload_d = rd_q[PAYLOAD_W-1:0];
						active_d       = 1'b1;
						head_d         = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
						count_d        = count_q - 1'b1;
					end
				end
			endcase
		end
	end

	// Control state registers and configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q         <= '0;
			tail_q         <= '0;
			count_q        <= '0;
			run_prev_q     <= 1'b0;
			countdown_q    <= '0;
			active_q       <= 1'b0;
			pend_label_q   <= '0;
			pend_payload_q <= '0;
			error_q        <= 1'b0;
			level_q        <= LEVEL_RESET;
		end else begin
			head_q         <= head_d;
			tail_q         <= tail_d;
			count_q        <= count_d;
			run_prev_q     <= run_prev_d;
			countdown_q    <= countdown_d;
			active_q       <= active_d;
			pend_label_q   <= pend_label_d;
			pend_payload_q <= pend_payload_d;
			error_q        <= error_d;
			if (cfg_we) begin
				level_q <= cfg_wdata;
			end
		end
	end

	// Result registers, updated once per executed item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid   <= 1'b0;
			out_label   <= '0;
			out_payload <= '0;
			almost_full <= 1'b0;
			queue_empty <= 1'b1;
			error_flag  <= 1'b0;
			overflow    <= 1'b0;
		end else if (cmd.exec) begin
			out_valid   <= valid_d;
			out_label   <= valid_d ? pend_label_q : '0;
			out_payload <= valid_d ? pend_payload_q : '0;
			almost_full <= (32'(count_d) >= 32'(level_q));
			queue_empty <= (count_d == '0);
			error_flag  <= error_d;
			overflow    <= ovf_d;
		end
	end

endmodule

// File: design/timed_event_queue_dispatcher_top.sv
`timescale 1ns / 1ps
// An accepted item is latched on entry to the execute state; its result is registered with done as that state ends.
// A new item is accepted only in the idle state, not while busy; busy is high for the one execute cycle.
// The event memory read is registered, so the head entry is fetched while the item is latched.
// Reset clears pointers, fill count, timing state and the error latch; level resets to 16.
// Results appear under a one-cycle done strobe, are held until the next executed item, and cannot be stalled.

`include "timed_event_queue_dispatcher_top_defines.svh"

module timed_event_queue_dispatcher_top #(
	parameter int QUEUE_DEPTH = teqd_pkg::DEF_QUEUE_DEPTH,
	parameter int WAIT_BITS   = teqd_pkg::DEF_WAIT_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	output logic                             done,
	input  logic                             opcode,
	input  logic [teqd_pkg::WAIT_IN_W-1:0]   delay_ticks,
	input  logic [teqd_pkg::LABEL_W-1:0]     event_label,
	input  logic [teqd_pkg::PAYLOAD_W-1:0]   event_payload,
	input  logic                             run_level,
	input  logic                             cfg_we,
	input  logic [teqd_pkg::LEVEL_W-1:0]     cfg_wdata,
	output logic                             out_valid,
	output logic [teqd_pkg::LABEL_W-1:0]     out_label,
	output logic [teqd_pkg::PAYLOAD_W-1:0]   out_payload,
	output logic                             almost_full,
	output logic                             queue_empty,
	output logic                             error_flag,
	output logic                             overflow
);
	import teqd_pkg::*;

	cmd_t cmd;

	// Controller.
	teqd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// Queue, timer and result datapath.
	teqd_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.WAIT_BITS   (WAIT_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.opcode        (opcode),
		.delay_ticks   (delay_ticks),
		.event_label   (event_label),
		.event_payload (event_payload),
		.run_level     (run_level),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.out_valid     (out_valid),
		.out_label     (out_label),
		.out_payload   (out_payload),
		.almost_full   (almost_full),
		.queue_empty   (queue_empty),
		.error_flag    (error_flag),
		.overflow      (overflow)
	);

	// An accepted item always moves into the execute cycle.
	`TEQD_ASSERT_NEXT(a_accept_exec, start && !busy, busy, "accepted item did not execute")
	// Execution ends in the next cycle, with the result strobe on done.
	`TEQD_ASSERT_NEXT(a_exec_one, busy, !busy && done, "execute cycle did not end in a result")
	// A dropped enqueue never releases an event.
	`TEQD_ASSERT_NOW(a_ovf_no_rel, done && overflow, !out_valid, "overflow with a released event")

endmodule
